>>> hdl/farthest_point_sampler_assert.svh
// Assertion helpers for the sampler. Both expect clk and rst_n in scope.
`ifndef FARTHEST_POINT_SAMPLER_ASSERT_SVH
`define FARTHEST_POINT_SAMPLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define FPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/fps_pkg.sv
`timescale 1ns / 1ps
package fps_pkg;

  localparam int FPS_MAX_POINTS  = 1024;
  localparam int FPS_MAX_SAMPLES = 64;
  localparam int FPS_COORD_BITS  = 16;

  localparam int FIELD_W        = 16;
  localparam int IDX_OUT_W      = 10;
  localparam int CFG_W          = 7;
  localparam int IN_DATA_W      = 48;
  localparam int OUT_DATA_W     = 64;
  localparam int OUT_PAD_W      = OUT_DATA_W - IDX_OUT_W - 3 * FIELD_W;
  localparam logic [CFG_W-1:0] SAMPLE_COUNT_RESET = 7'd16;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CTR_RD,
    ST_CAPTURE,
    ST_SWEEP,
    ST_DRAIN,
    ST_MARK
  } fps_state_t;

  // Control from the sequencer to the distance unit.
  typedef struct packed {
    logic issue;
    logic first_round;
    logic start_round;
    logic mark;
  } fps_sweep_ctl_t;

endpackage

>>> hdl/fps_point_mem.sv
`timescale 1ns / 1ps
module fps_point_mem
  import fps_pkg::*;
#(
  parameter int MAX_POINTS = FPS_MAX_POINTS,
  parameter int COORD_BITS = FPS_COORD_BITS,
  localparam int IDX_W = $clog2(MAX_POINTS),
  localparam int PT_W  = 3 * COORD_BITS
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [PT_W-1:0]  wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [PT_W-1:0]  rd_data
);

  logic [PT_W-1:0] mem [MAX_POINTS];
  logic [PT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read, so a captured point can wait.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/fps_dist_unit.sv
`timescale 1ns / 1ps
module fps_dist_unit
  import fps_pkg::*;
#(
  parameter int MAX_POINTS = FPS_MAX_POINTS,
  parameter int COORD_BITS = FPS_COORD_BITS,
  localparam int IDX_W  = $clog2(MAX_POINTS),
  localparam int PT_W   = 3 * COORD_BITS,
  localparam int DIST_W = 2 * COORD_BITS + 2,
  localparam int ABS_W  = COORD_BITS + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fps_sweep_ctl_t               ctl,
  input  logic [IDX_W-1:0]             rd_idx,
  input  logic [IDX_W-1:0]             mark_idx,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic signed [COORD_BITS-1:0] center_z,
  input  logic [PT_W-1:0]              pt_q,
  output logic                         busy,
  output logic [IDX_W-1:0]             best_idx
);

  `include "farthest_point_sampler_assert.svh"

  localparam logic [DIST_W-1:0] DIST_ONES = '1;

  // Each entry holds the taken mark above the running minimum distance.
  logic [DIST_W:0] dmem [MAX_POINTS];
  logic [DIST_W:0] dq_r;

  logic             p1_valid_r;
  logic [IDX_W-1:0] p1_idx_r;

  logic              p2_valid_r;
  logic [IDX_W-1:0]  p2_idx_r;
  logic              p2_taken_r;
  logic [DIST_W-1:0] p2_old_r;
  logic [ABS_W-1:0]  p2_ax_r, p2_ay_r, p2_az_r;

  logic              p3_valid_r;
  logic [IDX_W-1:0]  p3_idx_r;
  logic              p3_taken_r;
  logic [DIST_W-1:0] p3_old_r;
  logic [DIST_W-1:0] p3_sx_r, p3_sy_r, p3_sz_r;

  logic              p4_valid_r;
  logic [IDX_W-1:0]  p4_idx_r;
  logic              p4_taken_r;
  logic [DIST_W-1:0] p4_min_r;

  logic              found_r;
  logic [DIST_W-1:0] best_dist_r;
  logic [IDX_W-1:0]  best_idx_r;

  logic signed [COORD_BITS-1:0] px, py, pz;
  logic signed [COORD_BITS:0]   dx, dy, dz;
  logic [ABS_W-1:0]             ax, ay, az;
  logic [DIST_W-1:0]            s1_old;
  logic                         s1_taken;
  logic [DIST_W-1:0]            sum3, new_min;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic [DIST_W:0]              wr_data;

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      dq_r <= dmem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dmem[wr_addr] <= wr_data;
    end
  end

  // Stage 1: differences to the centre and their magnitudes.
  always_comb begin
    px = pt_q[COORD_BITS-1:0];
    py = pt_q[2*COORD_BITS-1:COORD_BITS];
    pz = pt_q[3*COORD_BITS-1:2*COORD_BITS];
    dx = {px[COORD_BITS-1], px} - {center_x[COORD_BITS-1], center_x};
    dy = {py[COORD_BITS-1], py} - {center_y[COORD_BITS-1], center_y};
    dz = {pz[COORD_BITS-1], pz} - {center_z[COORD_BITS-1], center_z};
    ax = dx[COORD_BITS] ? ABS_W'(-dx) : ABS_W'(dx);
    ay = dy[COORD_BITS] ? ABS_W'(-dy) : ABS_W'(dy);
    az = dz[COORD_BITS] ? ABS_W'(-dz) : ABS_W'(dz);
    // The first round of a set sees fresh entries: only point 0 is taken.
    if (ctl.first_round) begin
      s1_old   = DIST_ONES;
      s1_taken = (p1_idx_r == '0);
    end else begin
      s1_old   = dq_r[DIST_W-1:0];
      s1_taken = dq_r[DIST_W];
    end
  end

  // Stage 3: distance, new minimum and write-back.
  always_comb begin
    sum3    = p3_sx_r + p3_sy_r + p3_sz_r;
    new_min = (!p3_taken_r && (sum3 < p3_old_r)) ? sum3 : p3_old_r;
    if (ctl.mark) begin
      wr_en   = 1'b1;
      wr_addr = mark_idx;
      wr_data = {1'b1, best_dist_r};
    end else begin
      wr_en   = p3_valid_r;
      wr_addr = p3_idx_r;
      wr_data = {p3_taken_r, new_min};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
      p4_valid_r <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      p1_valid_r <= ctl.issue;
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
      p4_valid_r <= p3_valid_r;
      if (ctl.start_round) begin
        found_r <= 1'b0;
      end else if (p4_valid_r && !p4_taken_r) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_idx_r   <= rd_idx;
    p2_idx_r   <= p1_idx_r;
    p2_taken_r <= s1_taken;
    p2_old_r   <= s1_old;
    p2_ax_r    <= ax;
    p2_ay_r    <= ay;
    p2_az_r    <= az;
    p3_idx_r   <= p2_idx_r;
    p3_taken_r <= p2_taken_r;
    p3_old_r   <= p2_old_r;
    p3_sx_r    <= p2_ax_r * p2_ax_r;
    p3_sy_r    <= p2_ay_r * p2_ay_r;
    p3_sz_r    <= p2_az_r * p2_az_r;
    p4_idx_r   <= p3_idx_r;
    p4_taken_r <= p3_taken_r;
    p4_min_r   <= new_min;
    // Strictly greater wins, so on a tie the earlier index stays.
    if (p4_valid_r && !p4_taken_r && (!found_r || (p4_min_r > best_dist_r))) begin
      best_dist_r <= p4_min_r;
      best_idx_r  <= p4_idx_r;
    end
  end

  assign busy     = p1_valid_r | p2_valid_r | p3_valid_r | p4_valid_r;
  assign best_idx = best_idx_r;

  `FPS_ASSERT_NOW(a_mark_drained, ctl.mark, !busy, "mark write while sweep in flight")
  `FPS_ASSERT_NOW(a_mark_no_issue, ctl.mark, !ctl.issue, "mark write collides with a read")
  `FPS_ASSERT_NOW(a_mark_found, ctl.mark, found_r, "round closed without a candidate")

endmodule

>>> hdl/fps_ctrl.sv
`timescale 1ns / 1ps
module fps_ctrl
  import fps_pkg::*;
#(
  parameter int MAX_POINTS  = FPS_MAX_POINTS,
  parameter int MAX_SAMPLES = FPS_MAX_SAMPLES,
  parameter int COORD_BITS  = FPS_COORD_BITS,
  localparam int IDX_W  = $clog2(MAX_POINTS),
  localparam int CNT_W  = $clog2(MAX_POINTS + 1),
  localparam int SCNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int PT_W   = 3 * COORD_BITS,
  localparam int EXT_W  = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [IN_DATA_W-1:0]         in_tdata,
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [OUT_DATA_W-1:0]        out_tdata,
  output logic                         out_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_W-1:0]             cfg_data,
  output logic                         pt_wr_en,
  output logic [IDX_W-1:0]             pt_wr_addr,
  output logic [PT_W-1:0]              pt_wr_data,
  output logic                         pt_rd_en,
  output logic [IDX_W-1:0]             pt_rd_addr,
  input  logic [PT_W-1:0]              pt_rd_data,
  output fps_sweep_ctl_t               sweep_ctl,
  output logic [IDX_W-1:0]             mark_idx,
  output logic signed [COORD_BITS-1:0] center_x,
  output logic signed [COORD_BITS-1:0] center_y,
  output logic signed [COORD_BITS-1:0] center_z,
  input  logic                         dist_busy,
  input  logic [IDX_W-1:0]             best_idx
);

  `include "farthest_point_sampler_assert.svh"

  fps_state_t state_r, state_nxt;

  logic [CFG_W-1:0]      sample_count_r;
  logic [CNT_W-1:0]      loaded_r, loaded_nxt;
  logic [SCNT_W-1:0]     want_r, want_nxt;
  logic [SCNT_W-1:0]     emitted_r, emitted_nxt;
  logic [IDX_W-1:0]      center_idx_r, center_idx_nxt;
  logic [IDX_W-1:0]      vid_r, vid_nxt;
  logic                  first_round_r, first_round_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;
  logic signed [COORD_BITS-1:0] center_x_r, center_y_r, center_z_r;

  logic             in_acc;
  logic             store_room;
  logic             out_free;
  logic             cap_load;
  logic             cap_last;
  logic             sweep_end;
  logic [CNT_W-1:0] n_new;
  logic [31:0]      want_w;
  logic [EXT_W-1:0] ext_x, ext_y, ext_z;
  logic signed [COORD_BITS-1:0] qx, qy, qz;
  logic [31:0]      wide_x, wide_y, wide_z;

  assign in_acc     = in_tvalid && in_tready;
  assign store_room = (loaded_r < CNT_W'(MAX_POINTS));
  assign out_free   = !out_valid_r || out_tready;
  assign cap_last   = ({1'b0, emitted_r} + 1'b1) == {1'b0, want_r};
  assign sweep_end  = ({1'b0, vid_r} == (CNT_W'(loaded_r) - 1'b1));
  assign cap_load   = (state_r == ST_CAPTURE) && out_free;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_tlast) state_nxt = ST_CTR_RD;
      end
      ST_CTR_RD: begin
        state_nxt = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        if (out_free) state_nxt = cap_last ? ST_LOAD : ST_SWEEP;
      end
      ST_SWEEP: begin
        if (sweep_end) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!dist_busy) state_nxt = ST_MARK;
      end
      ST_MARK: begin
        state_nxt = ST_CTR_RD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    in_tready             = 1'b0;
    pt_rd_en              = 1'b0;
    pt_rd_addr            = center_idx_r;
    sweep_ctl.issue       = 1'b0;
    sweep_ctl.mark        = 1'b0;
    sweep_ctl.start_round = 1'b0;
    sweep_ctl.first_round = first_round_r;
    case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
      end
      ST_CTR_RD: begin
        pt_rd_en = 1'b1;
      end
      ST_CAPTURE: begin
        sweep_ctl.start_round = out_free && !cap_last;
      end
      ST_SWEEP: begin
        pt_rd_en        = 1'b1;
        pt_rd_addr      = vid_r;
        sweep_ctl.issue = 1'b1;
      end
      ST_MARK: begin
        sweep_ctl.mark = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Point write path: the low COORD_BITS of each zero-extended field.
  always_comb begin
    ext_x      = EXT_W'(in_tdata[FIELD_W-1:0]);
    ext_y      = EXT_W'(in_tdata[2*FIELD_W-1:FIELD_W]);
    ext_z      = EXT_W'(in_tdata[3*FIELD_W-1:2*FIELD_W]);
    pt_wr_en   = in_acc && store_room;
    pt_wr_addr = loaded_r[IDX_W-1:0];
    pt_wr_data = {ext_z[COORD_BITS-1:0], ext_y[COORD_BITS-1:0], ext_x[COORD_BITS-1:0]};
  end

  // Sample count clamped to [1, MAX_SAMPLES] and to the points held.
  always_comb begin
    n_new  = store_room ? (loaded_r + 1'b1) : loaded_r;
    want_w = (sample_count_r == '0) ? 32'd1 : 32'(sample_count_r);
    if (want_w > 32'(MAX_SAMPLES)) want_w = 32'(MAX_SAMPLES);
    if (want_w > 32'(n_new)) want_w = 32'(n_new);
  end

  always_comb begin
    qx     = pt_rd_data[COORD_BITS-1:0];
    qy     = pt_rd_data[2*COORD_BITS-1:COORD_BITS];
    qz     = pt_rd_data[3*COORD_BITS-1:2*COORD_BITS];
    wide_x = {{(32-COORD_BITS){qx[COORD_BITS-1]}}, qx};
    wide_y = {{(32-COORD_BITS){qy[COORD_BITS-1]}}, qy};
    wide_z = {{(32-COORD_BITS){qz[COORD_BITS-1]}}, qz};
  end

  // Register updates.
  always_comb begin
    loaded_nxt      = loaded_r;
    want_nxt        = want_r;
    emitted_nxt     = emitted_r;
    center_idx_nxt  = center_idx_r;
    vid_nxt         = vid_r;
    first_round_nxt = first_round_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    if (in_acc) begin
      loaded_nxt = n_new;
      if (in_tlast) begin
        want_nxt       = SCNT_W'(want_w);
        emitted_nxt    = '0;
        center_idx_nxt = '0;
      end
    end
    if (cap_load) begin
      out_valid_nxt = 1'b1;
      emitted_nxt   = emitted_r + 1'b1;
      vid_nxt       = '0;
      if (cap_last) begin
        loaded_nxt      = '0;
        first_round_nxt = 1'b1;
      end
    end
    if (state_r == ST_SWEEP) begin
      vid_nxt = vid_r + 1'b1;
    end
    if (state_r == ST_MARK) begin
      center_idx_nxt  = best_idx;
      first_round_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_LOAD;
      sample_count_r <= SAMPLE_COUNT_RESET;
      loaded_r       <= '0;
      want_r         <= '0;
      emitted_r      <= '0;
      center_idx_r   <= '0;
      vid_r          <= '0;
      first_round_r  <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      loaded_r      <= loaded_nxt;
      want_r        <= want_nxt;
      emitted_r     <= emitted_nxt;
      center_idx_r  <= center_idx_nxt;
      vid_r         <= vid_nxt;
      first_round_r <= first_round_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        sample_count_r <= cfg_data;
      end
    end
  end

  // The captured point is both the word to send and the next centre.
  always_ff @(posedge clk) begin
    if (cap_load) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, wide_z[FIELD_W-1:0], wide_y[FIELD_W-1:0],
                     wide_x[FIELD_W-1:0], IDX_OUT_W'(32'(center_idx_r))};
      out_last_r <= cap_last;
      center_x_r <= qx;
      center_y_r <= qy;
      center_z_r <= qz;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign mark_idx   = center_idx_nxt;
  assign center_x   = center_x_r;
  assign center_y   = center_y_r;
  assign center_z   = center_z_r;

  `FPS_ASSERT_NOW(a_emit_bound, state_r != ST_LOAD, emitted_r < want_r, "sample count overrun")
  `FPS_ASSERT_NOW(a_set_nonempty, state_r != ST_LOAD, loaded_r != '0, "sampling an empty set")
  `FPS_ASSERT_NEXT(a_cap_word, cap_load, out_valid_r, "captured sample not presented")

endmodule

>>> hdl/farthest_point_sampler.sv
`timescale 1ns / 1ps
// Greedy farthest-point sampler.
// Input channel (in_*): one point per word, x, y, z in tdata; tlast closes the set.
// Points are taken one per cycle while the block is loading; points beyond
// MAX_POINTS are dropped, but a dropped word with tlast still closes the set.
// Output channel (out_*): one word per sample in pick order, point 0 first;
// tlast marks the final sample. Samples = sample_count clamped to [1, MAX_SAMPLES]
// and to the points loaded.
// Configuration (cfg_*): sample_count, always ready; write it between sets.
// After the closing word the centre point is read, and the first sample is
// registered once the output register is free. Each further sample costs one
// sweep over the n points held: the point and distance memories are read once
// per point per round, through a four-stage distance pipeline, followed by a
// mark write and a centre read. No point of the next set is accepted until the
// last sample of this set has been registered.
// The output register keeps its word while out_tready is low; a stalled
// receiver only holds the start of the next round, never loses a sample.
// Reset (rst_n low, synchronous) empties the set and sets sample_count to 16;
// point memory contents are not cleared and need no clearing.
module farthest_point_sampler
  import fps_pkg::*;
#(
  parameter int MAX_POINTS  = FPS_MAX_POINTS,
  parameter int MAX_SAMPLES = FPS_MAX_SAMPLES,
  parameter int COORD_BITS  = FPS_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // x_coord, y_coord, z_coord
  input  logic                  in_tlast,   // last_point
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // point_index, out_x, out_y, out_z, zero pad
  output logic                  out_tlast,  // last_sample
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data    // sample_count
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int PT_W  = 3 * COORD_BITS;

  logic                         pt_wr_en;
  logic [IDX_W-1:0]             pt_wr_addr;
  logic [PT_W-1:0]              pt_wr_data;
  logic                         pt_rd_en;
  logic [IDX_W-1:0]             pt_rd_addr;
  logic [PT_W-1:0]              pt_rd_data;
  fps_sweep_ctl_t               sweep_ctl;
  logic [IDX_W-1:0]             mark_idx;
  logic signed [COORD_BITS-1:0] center_x, center_y, center_z;
  logic                         dist_busy;
  logic [IDX_W-1:0]             best_idx;

  fps_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_SAMPLES(MAX_SAMPLES),
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .pt_wr_en   (pt_wr_en),
    .pt_wr_addr (pt_wr_addr),
    .pt_wr_data (pt_wr_data),
    .pt_rd_en   (pt_rd_en),
    .pt_rd_addr (pt_rd_addr),
    .pt_rd_data (pt_rd_data),
    .sweep_ctl  (sweep_ctl),
    .mark_idx   (mark_idx),
    .center_x   (center_x),
    .center_y   (center_y),
    .center_z   (center_z),
    .dist_busy  (dist_busy),
    .best_idx   (best_idx)
  );

  fps_point_mem #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_point_mem (
    .clk     (clk),
    .wr_en   (pt_wr_en),
    .wr_addr (pt_wr_addr),
    .wr_data (pt_wr_data),
    .rd_en   (pt_rd_en),
    .rd_addr (pt_rd_addr),
    .rd_data (pt_rd_data)
  );

  fps_dist_unit #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_dist_unit (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sweep_ctl),
    .rd_idx   (pt_rd_addr),
    .mark_idx (mark_idx),
    .center_x (center_x),
    .center_y (center_y),
    .center_z (center_z),
    .pt_q     (pt_rd_data),
    .busy     (dist_busy),
    .best_idx (best_idx)
  );

endmodule
